// ----- rtl/lph_pkg.sv -----
// ----------------------------------------------------------------------------
// lph_pkg
// Shared types and constants for the linear probing hash map.
// ----------------------------------------------------------------------------
package lph_pkg;

  // fixed field widths of the request and response
  localparam int KEY_W = 17;
  localparam int OCC_W = 12;

  // operation codes
  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_INSERT = 1'b1;

  typedef struct packed {
    logic             func;
    logic [KEY_W-1:0] key;
    logic             entry_value;
  } lph_in_t;

  typedef struct packed {
    logic             found;
    logic             read_value;
    logic             added_new;
    logic             table_full;
    logic [OCC_W-1:0] occupancy;
  } lph_out_t;

endpackage

// ----- rtl/linear_probe_hash_map.sv -----
// ----------------------------------------------------------------------------
// linear_probe_hash_map
// Open-addressing hash map with linear probing over one table RAM.
// A request passes the hash, probe and done states; the probe walk reads
// P slots (1..SLOTS), one probe per cycle through the RAM read port. The
// home slot comes from a division of the key when SLOTS is not a power of
// two. One request at a time.
// Reset: a clearing pass over all SLOTS entries empties the table, req_stall high.
// ----------------------------------------------------------------------------
module linear_probe_hash_map #(
  parameter int SLOTS    = 2048,
  parameter int KEY_BITS = 17
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  lph_pkg::lph_in_t req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output lph_pkg::lph_out_t rsp
);

  import lph_pkg::*;

  localparam int IDX_W  = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int WORD_W = KEY_BITS + 2;
  localparam int KX     = KEY_BITS + KEY_W;
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOTS - 1);
  localparam logic [CNT_W-1:0] ALL_PROBES = CNT_W'(SLOTS);

  // controller states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_PROBE = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]          state;
  logic [2:0]          state_next;
  logic [IDX_W-1:0]    clr_addr;
  logic                op_q;
  logic [KEY_BITS-1:0] key_q;
  logic                val_q;
  logic [IDX_W-1:0]    pos;
  logic [IDX_W-1:0]    pos_inc;
  logic [CNT_W-1:0]    probes;
  logic [OCC_W-1:0]    used_count;
  lph_out_t            result;

  logic [KX-1:0]       key_ext;
  logic [KEY_BITS-1:0] key_m;
  logic                req_xfer;
  logic                home_done;
  logic [IDX_W-1:0]    home;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [WORD_W-1:0]   ram_wdata;
  logic                ram_re;
  logic [IDX_W-1:0]    ram_raddr;
  logic [WORD_W-1:0]   ram_rdata;

  logic                slot_valid;
  logic                slot_value;
  logic [KEY_BITS-1:0] slot_key;
  logic                hit;
  logic                empty;
  logic                exhausted;
  logic                finish;
  logic                fill;
  logic                rsp_load;

  // key bits above KEY_BITS are dropped
  assign key_ext  = KX'(req.key);
  assign key_m    = key_ext[KEY_BITS-1:0];
  assign req_stall = (state != S_IDLE);
  assign req_xfer  = req_valid && !req_stall;

  lph_home #(
    .SLOTS    (SLOTS),
    .KEY_BITS (KEY_BITS)
  ) u_home (
    .clk   (clk),
    .rst   (rst),
    .start (req_xfer),
    .key   (key_m),
    .done  (home_done),
    .home  (home)
  );

  // probe decode of the word read last cycle
  assign slot_valid = ram_rdata[WORD_W-1];
  assign slot_value = ram_rdata[KEY_BITS];
  assign slot_key   = ram_rdata[KEY_BITS-1:0];
  assign empty      = !slot_valid;
  assign hit        = slot_valid && (slot_key == key_q);
  assign exhausted  = (probes == ALL_PROBES);
  assign finish     = (state == S_PROBE) && (hit || empty || exhausted);
  assign fill       = (state == S_PROBE) && empty && (op_q == FUNC_INSERT);
  assign pos_inc    = (pos == LAST_SLOT) ? '0 : pos + IDX_W'(1);

  // table RAM ports
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = pos_inc;
    if (state == S_HASH) begin
      ram_re    = home_done;
      ram_raddr = home;
    end else if (state == S_PROBE) begin
      ram_re = !finish;
    end
  end

  always_comb begin
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = (state == S_PROBE) && (op_q == FUNC_INSERT) && (hit || empty);
      ram_waddr = pos;
      ram_wdata = {1'b1, val_q, key_q};
    end
  end

  lph_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rsp_load = (state == S_DONE) && (!rsp_valid || !rsp_stall);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_addr == LAST_SLOT) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_xfer) begin
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        if (home_done) begin
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        if (finish) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (rsp_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      used_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + IDX_W'(1);
      end
      if (fill) begin
        used_count <= used_count + OCC_W'(1);
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // request capture and probe walk
  always_ff @(posedge clk) begin
    if (req_xfer) begin
      op_q  <= req.func;
      key_q <= key_m;
      val_q <= req.entry_value;
    end
    if (state == S_HASH && home_done) begin
      pos    <= home;
      probes <= CNT_W'(1);
    end else if (state == S_PROBE && !finish) begin
      pos    <= pos_inc;
      probes <= probes + CNT_W'(1);
    end
  end

  // result of the finished probe walk
  always_ff @(posedge clk) begin
    if (finish) begin
      result.found      <= hit;
      result.read_value <= hit && (op_q == FUNC_LOOKUP) && slot_value;
      result.added_new  <= fill;
      result.table_full <= !hit && !empty;
      result.occupancy  <= used_count + OCC_W'(fill);
    end
  end

  // response output register
  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= result;
    end
  end

`ifndef SYNTH
  a_probe_write_insert: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE && ram_we) |-> (op_q == FUNC_INSERT))
    else $error("table written during a lookup probe");

  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE) |-> (probes != '0 && probes <= ALL_PROBES))
    else $error("probe count out of range");

  a_count_only_on_fill: assert property (@(posedge clk) disable iff (rst)
    (state != S_CLEAR && !fill) |=> $stable(used_count))
    else $error("occupancy changed without a new slot");

  a_home_in_hash: assert property (@(posedge clk) disable iff (rst)
    home_done |-> (state == S_HASH))
    else $error("home slot ready outside hash state");
`endif

endmodule

// ----- rtl/lph_ram.sv -----
// ----------------------------------------------------------------------------
// lph_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module lph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/lph_home.sv -----
// ----------------------------------------------------------------------------
// lph_home
// Home slot unit: key mod SLOTS. A mask when SLOTS is a power of two,
// otherwise a long division retiring four key bits per cycle.
// ----------------------------------------------------------------------------
module lph_home #(
  parameter int SLOTS    = 2048,
  parameter int KEY_BITS = 17
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [KEY_BITS-1:0]      key,
  output logic                     done,
  output logic [$clog2(SLOTS)-1:0] home
);

  localparam int  IDX_W = $clog2(SLOTS);
  localparam bit  POW2  = ((SLOTS & (SLOTS - 1)) == 0);

  if (POW2) begin : g_mask
    localparam int KX = KEY_BITS + IDX_W;
    logic [KX-1:0]    key_ext;
    logic [IDX_W-1:0] home_q;

    assign key_ext = KX'(key);

    // low bits are the home slot; ready the cycle after start
    always_ff @(posedge clk) begin
      if (rst) begin
        done <= 1'b0;
      end else begin
        done <= start;
      end
    end

    always_ff @(posedge clk) begin
      if (start) begin
        home_q <= key_ext[IDX_W-1:0];
      end
    end

    assign home = home_q;

  end else begin : g_div
    localparam int DIG  = 4;
    localparam int ND   = (KEY_BITS + DIG - 1) / DIG;
    localparam int PADW = ND * DIG;
    localparam int ND_W = $clog2(ND + 1);
    localparam logic [IDX_W:0] MODV = (IDX_W + 1)'(SLOTS);

    logic [PADW-1:0]  shreg;
    logic [IDX_W-1:0] acc;
    logic [IDX_W-1:0] acc_next;
    logic [ND_W-1:0]  cnt;
    logic             busy;
    logic [IDX_W-1:0] rem;
    logic [IDX_W:0]   trial;

    // one digit: shift in DIG key bits, reduce after each
    always_comb begin
      rem = acc;
      trial = '0;
      for (int i = 0; i < DIG; i++) begin
        trial = {rem, shreg[PADW-1-i]};
        if (trial >= MODV) begin
          trial = trial - MODV;
        end
        rem = trial[IDX_W-1:0];
      end
      acc_next = rem;
    end

    // digit sequencer
    always_ff @(posedge clk) begin
      if (rst) begin
        busy <= 1'b0;
        done <= 1'b0;
      end else begin
        done <= 1'b0;
        if (start) begin
          busy <= 1'b1;
        end else if (busy && cnt == ND_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (start) begin
        acc   <= '0;
        shreg <= PADW'(key);
        cnt   <= ND_W'(ND);
      end else if (busy) begin
        acc   <= acc_next;
        shreg <= shreg << DIG;
        cnt   <= cnt - ND_W'(1);
      end
    end

    assign home = acc;
  end

endmodule

// ----- tb/sv/linear_probe_hash_map_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_map_test
// Self-checking bench for the linear probing hash map. Directed tests hit
// the empty table, updates, collision chains and wraparound. One long
// response hold-off and a random mix of lookups and inserts follow. Last,
// every slot is filled and the full-table behavior is checked. A shadow
// table in the bench predicts each response, and responses are compared
// field by field in arrival order.
// ----------------------------------------------------------------------------
module linear_probe_hash_map_test;
  import lph_pkg::*;

  localparam int SLOTS      = 2048;
  localparam int KEY_MAX    = 99999;
  localparam int IDLE_LIMIT = 20000;
  localparam int TAIL_WAIT  = 64;
  localparam int RANDOM_OPS = 400;

  logic     clk;
  logic     rst;
  logic     req_valid;
  logic     req_stall;
  lph_in_t  req;
  logic     rsp_valid;
  logic     rsp_stall;
  lph_out_t rsp;

  // shadow copy of the table
  bit [KEY_W-1:0] shadow_key [SLOTS];
  bit             shadow_val [SLOTS];
  bit             shadow_used[SLOTS];
  bit [OCC_W-1:0] shadow_occ;

  lph_out_t       pending_rsp[$];
  bit [KEY_W-1:0] stored_keys[$];
  int             errors    = 0;
  int             burst_left = 0;
  int             hold_left = 0;
  int             mode_left = 0;
  int             stall_mode = 0;

  linear_probe_hash_map #(
    .SLOTS   (SLOTS),
    .KEY_BITS(KEY_W)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Probe the shadow table and apply one request to it.
  function automatic lph_out_t hash_map_apply(lph_in_t r);
    lph_out_t    o;
    int unsigned pos;
    int          n;
    bit          hit;
    bit          empty;
    o     = '0;
    pos   = r.key % SLOTS;
    hit   = 1'b0;
    empty = 1'b0;
    for (n = 0; n < SLOTS && !hit && !empty; n++) begin
      if (!shadow_used[pos]) empty = 1'b1;
      else if (shadow_key[pos] == r.key) hit = 1'b1;
      else pos = (pos + 1) % SLOTS;
    end
    if (hit) begin
      o.found = 1'b1;
      if (r.func == FUNC_INSERT) shadow_val[pos] = r.entry_value;
      else o.read_value = shadow_val[pos];
    end else if (empty) begin
      if (r.func == FUNC_INSERT) begin
        shadow_key[pos]  = r.key;
        shadow_val[pos]  = r.entry_value;
        shadow_used[pos] = 1'b1;
        shadow_occ       = shadow_occ + 1'b1;
        o.added_new      = 1'b1;
      end
    end else begin
      o.table_full = 1'b1;
    end
    o.occupancy = shadow_occ;
    return o;
  endfunction

  // Sender pacing: bursts of random length, random gaps in between.
  task automatic pace_req();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(0, 12);
      if ($urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 9);
        req_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // Offer one request at the falling edge and hold it until the transfer.
  task automatic send_req(input logic f, input int unsigned k, input logic v);
    req.func        <= f;
    req.key         <= k[KEY_W-1:0];
    req.entry_value <= v;
    req_valid       <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
    pace_req();
  endtask

  // Receiver: stall pattern switching between modes, plus forced hold-offs.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left--;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(16, 128);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: rsp_stall <= 1'b0;
        1: rsp_stall <= ($urandom_range(0, 3) == 0);
        default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Check responses against the oldest prediction, then predict new requests.
  always @(posedge clk) begin : monitor
    lph_out_t want;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (pending_rsp.size() == 0) begin
          $error("response transfer with no request outstanding");
          errors++;
        end else begin
          want = pending_rsp.pop_front();
          if (rsp.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, rsp.found);
            errors++;
          end
          if (rsp.read_value !== want.read_value) begin
            $error("read_value: expected %0d, got %0d", want.read_value, rsp.read_value);
            errors++;
          end
          if (rsp.added_new !== want.added_new) begin
            $error("added_new: expected %0d, got %0d", want.added_new, rsp.added_new);
            errors++;
          end
          if (rsp.table_full !== want.table_full) begin
            $error("table_full: expected %0d, got %0d", want.table_full, rsp.table_full);
            errors++;
          end
          if (rsp.occupancy !== want.occupancy) begin
            $error("occupancy: expected %0d, got %0d", want.occupancy, rsp.occupancy);
            errors++;
          end
        end
      end
      if (req_valid && !req_stall) pending_rsp.push_back(hash_map_apply(req));
    end
  end

  // Watchdog: ends the run after too many cycles without any transfer.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
      else quiet++;
    end
    $display("status: fail");
    $finish;
  end

  // Lookups on the empty table miss.
  task automatic test_empty_lookup();
    send_req(FUNC_LOOKUP, 0, 1'b1);
    send_req(FUNC_LOOKUP, KEY_MAX, 1'b0);
  endtask

  // New inserts, updates of present keys, and lookups of both.
  task automatic test_insert_update();
    send_req(FUNC_INSERT, 0, 1'b1);
    send_req(FUNC_INSERT, KEY_MAX, 1'b0);
    send_req(FUNC_LOOKUP, 0, 1'b0);
    send_req(FUNC_LOOKUP, KEY_MAX, 1'b1);
    send_req(FUNC_INSERT, KEY_MAX, 1'b1);
    send_req(FUNC_LOOKUP, KEY_MAX, 1'b0);
    send_req(FUNC_INSERT, 0, 1'b1);
  endtask

  // Keys sharing one home slot build a probe chain.
  task automatic test_collision_chain();
    send_req(FUNC_INSERT, 5, 1'b1);
    send_req(FUNC_INSERT, 5 + SLOTS, 1'b0);
    send_req(FUNC_INSERT, 5 + 2 * SLOTS, 1'b1);
    send_req(FUNC_LOOKUP, 5 + 2 * SLOTS, 1'b0);
    send_req(FUNC_LOOKUP, 5 + 3 * SLOTS, 1'b1);
    send_req(FUNC_INSERT, 5 + SLOTS, 1'b1);
    send_req(FUNC_LOOKUP, 5 + SLOTS, 1'b0);
  endtask

  // Probe from the last slot wraps to slot 0, which already holds key 0.
  task automatic test_wraparound();
    send_req(FUNC_INSERT, SLOTS - 1, 1'b0);
    send_req(FUNC_INSERT, 2 * SLOTS - 1, 1'b1);
    send_req(FUNC_LOOKUP, 2 * SLOTS - 1, 1'b0);
    send_req(FUNC_LOOKUP, 3 * SLOTS - 1, 1'b0);
  endtask

  // Long response hold-off while requests keep coming back to back.
  task automatic test_backpressure();
    int n;
    hold_left  = 300;
    burst_left = 20;
    for (n = 0; n < 12; n++)
      send_req(n[0] ? FUNC_INSERT : FUNC_LOOKUP, $urandom_range(0, KEY_MAX),
               1'($urandom_range(0, 1)));
  endtask

  // Random mix: hits, misses, updates, fresh keys and one hot cluster.
  task automatic test_random_mix();
    int          n;
    int unsigned pick;
    int unsigned k;
    logic        f;
    for (n = 0; n < RANDOM_OPS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30 && stored_keys.size() > 0) begin
        f = FUNC_LOOKUP;
        k = 32'(stored_keys[$urandom_range(0, stored_keys.size() - 1)]);
      end else if (pick < 45) begin
        f = FUNC_LOOKUP;
        k = $urandom_range(0, KEY_MAX);
      end else if (pick < 60 && stored_keys.size() > 0) begin
        f = FUNC_INSERT;
        k = 32'(stored_keys[$urandom_range(0, stored_keys.size() - 1)]);
      end else if (pick < 70) begin
        f = FUNC_INSERT;
        k = 300 + $urandom_range(0, 15) + SLOTS * $urandom_range(0, 47);
      end else begin
        f = FUNC_INSERT;
        k = $urandom_range(0, KEY_MAX);
      end
      if (f == FUNC_INSERT) stored_keys.push_back(k[KEY_W-1:0]);
      send_req(f, k, 1'($urandom_range(0, 1)));
    end
  endtask

  // Fill every empty slot at its home position, then probe the full table.
  task automatic test_full_table();
    int          s;
    int unsigned k;
    bit          present;
    for (s = 0; s < SLOTS; s++) begin
      if (!shadow_used[s])
        send_req(FUNC_INSERT, s + SLOTS * $urandom_range(0, (KEY_MAX - s) / SLOTS),
                 1'($urandom_range(0, 1)));
    end
    // pick a key that is not stored anywhere
    do begin
      k       = $urandom_range(0, KEY_MAX);
      present = 1'b0;
      for (s = 0; s < SLOTS; s++)
        if (shadow_key[s] == k[KEY_W-1:0]) present = 1'b1;
    end while (present);
    send_req(FUNC_LOOKUP, k, 1'b1);
    send_req(FUNC_INSERT, k, 1'b1);
    k = 32'(shadow_key[$urandom_range(0, SLOTS - 1)]);
    send_req(FUNC_LOOKUP, k, 1'b0);
    send_req(FUNC_INSERT, k, 1'b1);
    send_req(FUNC_LOOKUP, k, 1'b0);
  endtask

  initial begin : run
    int waited;
    rst         = 1'b1;
    req_valid   = 1'b0;
    req         = '0;
    rsp_stall   = 1'b0;
    shadow_occ  = '0;
    foreach (shadow_used[i]) begin
      shadow_used[i] = 1'b0;
      shadow_key[i]  = '0;
      shadow_val[i]  = 1'b0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_lookup();
    test_insert_update();
    test_collision_chain();
    test_wraparound();
    test_backpressure();
    test_random_mix();
    test_full_table();
    req_valid <= 1'b0;

    // drain, then let any stray response show up
    waited = 0;
    while (pending_rsp.size() != 0 && waited < IDLE_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_WAIT) @(posedge clk);
    if (pending_rsp.size() != 0) begin
      $error("%0d responses never arrived", pending_rsp.size());
      errors++;
    end

    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/lph_pkg.sv
rtl/lph_ram.sv
rtl/lph_home.sv
rtl/linear_probe_hash_map.sv
tb/sv/linear_probe_hash_map_test.sv
